// File: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared constants for the LRU key-value cache
// Register map, command codes, reset values and default sizing.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_CAPACITY = 1'b0;   // paddr[2] selects the register

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // request commands
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // read_value returned by a get that misses
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

endpackage

// File: rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// One request (get or put) in, one result out. Entries live in a single
// memory word {key, value, recency rank}; a small sequencer sweeps it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: valid/ready beat carrying cmd (0 get, 1 put), key and
//   value. Output channel out_*: one beat per request with found, read_value
//   (stored value on get hit, -1 on get miss, 0 for put) and evicted.
//   cfg_* is an APB-style port; register 0 is capacity_in_use (5 bits,
//   reset 16, 0 acts as 1, values above MAX_ENTRIES act as MAX_ENTRIES).
// Sequencing:
//   One request at a time. A lookup sweep reads one entry per cycle, a
//   decide step follows, then a second sweep rewrites ranks/data and a
//   finish step loads the result; a get miss skips the second sweep. The
//   result and in_ready come together once the output register is free.
//   One entry memory read port and one key comparator set this pace.
// Reset:
//   All valid bits and occupancy clear at once; the store starts empty.
// Stall:
//   The result sits in an output register. The next request is accepted
//   while it waits; that request's result is held back until out_ready.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic signed [lkv_pkg::KEY_W-1:0]    in_key,
  input  logic signed [lkv_pkg::VAL_W-1:0]    in_value,

  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic signed [lkv_pkg::VAL_W-1:0]    out_read_value,
  output logic                                out_evicted,

  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [lkv_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [lkv_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [lkv_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_ENTRIES);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  typedef struct packed {
    logic [lkv_pkg::KEY_W-1:0] key;
    logic [lkv_pkg::VAL_W-1:0] value;
    logic [IDX_W-1:0]          rank;   // 0 = most recent
  } entry_t;

  // ---------------------------------------------------------------------------
  // Entry memory: one write, one registered read per cycle
  // ---------------------------------------------------------------------------
  entry_t           mem [MAX_ENTRIES];
  entry_t           rdata_r;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  entry_t           mem_wdata;

  // control
  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;        // sweep read pointer
  logic                   pv_r, pv_nxt;          // read data valid next cycle
  logic [IDX_W-1:0]       pidx_r, pidx_nxt;      // index of rdata_r
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       occ_r, occ_nxt;
  logic [lkv_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // request payload
  logic                      cmd_r, cmd_nxt;
  logic [lkv_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [lkv_pkg::VAL_W-1:0] value_r, value_nxt;

  // lookup sweep results
  logic                      hit_r, hit_nxt;
  logic [IDX_W-1:0]          hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]          hit_rank_r, hit_rank_nxt;
  logic [lkv_pkg::VAL_W-1:0] hit_val_r, hit_val_nxt;
  logic                      lru_any_r, lru_any_nxt;
  logic [IDX_W-1:0]          lru_idx_r, lru_idx_nxt;
  logic [IDX_W-1:0]          lru_rank_r, lru_rank_nxt;
  logic                      free_any_r, free_any_nxt;
  logic [IDX_W-1:0]          free_idx_r, free_idx_nxt;

  // update sweep control
  logic                      touch_r, touch_nxt;   // 1 = touch, 0 = insert
  logic [IDX_W-1:0]          tgt_r, tgt_nxt;

  // result
  logic                      res_found_r, res_found_nxt;
  logic [lkv_pkg::VAL_W-1:0] res_rd_r, res_rd_nxt;
  logic                      res_ev_r, res_ev_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [lkv_pkg::VAL_W-1:0] out_rd_r, out_rd_nxt;
  logic                      out_ev_r, out_ev_nxt;

  // helpers
  logic        cfg_wr;
  logic        in_acc;
  logic        cur_v;
  logic [31:0] cap_ext, max_ext, eff_cap, occ_ext;
  logic        is_full;
  logic        do_evict;
  logic [IDX_W-1:0] ins_slot;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite
                    & (cfg_paddr[2] == lkv_pkg::CFG_IDX_CAPACITY);
  assign cfg_prdata = (cfg_paddr[2] == lkv_pkg::CFG_IDX_CAPACITY)
                    ? {{(lkv_pkg::CFG_DATA_W - lkv_pkg::CAP_W){1'b0}}, cap_r}
                    : '0;

  assign in_ready       = (state_r == S_IDLE);
  assign in_acc         = in_valid & in_ready;
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_rd_r;
  assign out_evicted    = out_ev_r;

  // effective capacity: clamp to 1..MAX_ENTRIES
  assign cap_ext = 32'(cap_r);
  assign max_ext = 32'(MAX_ENTRIES);
  assign occ_ext = 32'(occ_r);
  assign eff_cap = (cap_r == '0) ? 32'd1 : ((cap_ext > max_ext) ? max_ext : cap_ext);
  assign is_full = (occ_ext >= eff_cap) && (occ_r != '0);

  assign do_evict = (cmd_r == lkv_pkg::CMD_PUT) && !hit_r && is_full;
  // first free slot once the victim is gone
  assign ins_slot = do_evict
                  ? ((free_any_r && (free_idx_r < lru_idx_r)) ? free_idx_r : lru_idx_r)
                  : free_idx_r;

  assign cur_v = valid_r[pidx_r];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    valid_nxt     = valid_r;
    occ_nxt       = occ_r;
    cap_nxt       = cfg_wr ? cfg_pwdata[lkv_pkg::CAP_W-1:0] : cap_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rank_nxt  = hit_rank_r;
    hit_val_nxt   = hit_val_r;
    lru_any_nxt   = lru_any_r;
    lru_idx_nxt   = lru_idx_r;
    lru_rank_nxt  = lru_rank_r;
    free_any_nxt  = free_any_r;
    free_idx_nxt  = free_idx_r;
    touch_nxt     = touch_r;
    tgt_nxt       = tgt_r;
    res_found_nxt = res_found_r;
    res_rd_nxt    = res_rd_r;
    res_ev_nxt    = res_ev_r;
    out_found_nxt = out_found_r;
    out_rd_nxt    = out_rd_r;
    out_ev_nxt    = out_ev_r;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r[IDX_W-1:0];
    mem_we        = 1'b0;
    mem_wdata     = rdata_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // sweep read side, shared by both passes
    if ((state_r == S_SCAN || state_r == S_UPDATE) && (cnt_r != CNT_END)) begin
      mem_re   = 1'b1;
      pv_nxt   = 1'b1;
      pidx_nxt = cnt_r[IDX_W-1:0];
      cnt_nxt  = cnt_r + CNT_W'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt      = in_cmd;
          key_nxt      = in_key;
          value_nxt    = in_value;
          hit_nxt      = 1'b0;
          lru_any_nxt  = 1'b0;
          free_any_nxt = 1'b0;
          cnt_nxt      = '0;
          state_nxt    = S_SCAN;
        end
      end

      S_SCAN: begin
        if (pv_r) begin
          // one key compare and one rank compare per entry
          if (cur_v && (rdata_r.key == key_r) && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = pidx_r;
            hit_rank_nxt = rdata_r.rank;
            hit_val_nxt  = rdata_r.value;
          end
          if (cur_v && (!lru_any_r || (rdata_r.rank > lru_rank_r))) begin
            lru_any_nxt  = 1'b1;
            lru_idx_nxt  = pidx_r;
            lru_rank_nxt = rdata_r.rank;
          end
          if (!cur_v && !free_any_r) begin
            free_any_nxt = 1'b1;
            free_idx_nxt = pidx_r;
          end
          if (cnt_r == CNT_END) begin
            state_nxt = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        cnt_nxt = '0;
        if (hit_r) begin
          res_found_nxt = 1'b1;
          res_rd_nxt    = (cmd_r == lkv_pkg::CMD_GET) ? hit_val_r : '0;
          res_ev_nxt    = 1'b0;
          touch_nxt     = 1'b1;
          tgt_nxt       = hit_idx_r;
          state_nxt     = S_UPDATE;
        end else if (cmd_r == lkv_pkg::CMD_GET) begin
          res_found_nxt = 1'b0;
          res_rd_nxt    = lkv_pkg::MISS_VALUE;
          res_ev_nxt    = 1'b0;
          state_nxt     = S_FINISH;
        end else begin
          // put miss: drop the victim if full, then claim a slot
          res_found_nxt = 1'b0;
          res_rd_nxt    = '0;
          res_ev_nxt    = do_evict;
          touch_nxt     = 1'b0;
          tgt_nxt       = ins_slot;
          if (do_evict) begin
            valid_nxt[lru_idx_r] = 1'b0;
          end else begin
            occ_nxt = occ_r + CNT_W'(1);
          end
          valid_nxt[ins_slot] = 1'b1;
          state_nxt = S_UPDATE;
        end
      end

      S_UPDATE: begin
        if (pv_r) begin
          mem_we = 1'b1;
          if (touch_r) begin
            if (pidx_r == tgt_r) begin
              mem_wdata.rank = '0;
              if (cmd_r == lkv_pkg::CMD_PUT) begin
                mem_wdata.value = value_r;
              end
            end else if (cur_v && (rdata_r.rank < hit_rank_r)) begin
              mem_wdata.rank = rdata_r.rank + IDX_W'(1);
            end
          end else begin
            if (pidx_r == tgt_r) begin
              mem_wdata.key   = key_r;
              mem_wdata.value = value_r;
              mem_wdata.rank  = '0;
            end else if (cur_v) begin
              mem_wdata.rank = rdata_r.rank + IDX_W'(1);
            end
          end
          if (cnt_r == CNT_END) begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_rd_nxt    = res_rd_r;
          out_ev_nxt    = res_ev_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pidx_r] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      valid_r     <= '0;
      occ_r       <= '0;
      cap_r       <= lkv_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      valid_r     <= valid_nxt;
      occ_r       <= occ_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pidx_r      <= pidx_nxt;
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    value_r     <= value_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    hit_val_r   <= hit_val_nxt;
    lru_any_r   <= lru_any_nxt;
    lru_idx_r   <= lru_idx_nxt;
    lru_rank_r  <= lru_rank_nxt;
    free_any_r  <= free_any_nxt;
    free_idx_r  <= free_idx_nxt;
    touch_r     <= touch_nxt;
    tgt_r       <= tgt_nxt;
    res_found_r <= res_found_nxt;
    res_rd_r    <= res_rd_nxt;
    res_ev_r    <= res_ev_nxt;
    out_found_r <= out_found_nxt;
    out_rd_r    <= out_rd_nxt;
    out_ev_r    <= out_ev_nxt;
  end

endmodule

// File: bench/lru_key_value_cache_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_test: self-checking bench for the LRU key-value cache
// Drives get/put beats with random gaps and back-pressure. A shadow copy of
// the store (valid bits, keys, values, recency ranks) predicts found,
// read_value and evicted for every accepted request. Capacity is reprogrammed
// between phases over the APB port and read back.
// ----------------------------------------------------------------------------
module lru_key_value_cache_test;
  import lkv_pkg::*;

  localparam int ENTRIES = MAX_ENTRIES_DEF;
  localparam int RANK_W = $clog2(ENTRIES);
  // wait after a drain; leaves margin for any sweep still in progress
  localparam int SWEEP_LATENCY = 2 * ENTRIES + 8;
  localparam int CYCLE_LIMIT = 600_000;
  localparam int LONG_HOLD = 400;
  localparam logic [CFG_ADDR_W-1:0] CAP_ADDR = {CFG_IDX_CAPACITY, 2'b00};
  // register index 1 lies beyond the map; writes there must not land anywhere
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = {~CFG_IDX_CAPACITY, 2'b00};
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } lookup_result_t;

  // Shadow copy of the store. Ranks: 0 is most recent, occupancy-1 least.
  class cache_shadow;
    logic               slot_valid [ENTRIES];
    logic [KEY_W-1:0]   slot_key   [ENTRIES];
    logic [VAL_W-1:0]   slot_value [ENTRIES];
    logic [RANK_W-1:0]  slot_rank  [ENTRIES];
    int unsigned        occupancy;
    logic [CAP_W-1:0]   capacity_reg;
    lookup_result_t     owed_results[$];
    int unsigned        failures;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_rank[i]  = '0;
      end
      occupancy    = 0;
      capacity_reg = CAP_RESET;
      failures     = 0;
    endfunction

    function void log_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("%0t ns: %s", $realtime, msg);
      end
    endfunction

    // zero acts as one, anything above the slot count as the slot count
    function int unsigned capacity_limit();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > ENTRIES) return ENTRIES;
      return capacity_reg;
    endfunction

    function void set_capacity(logic [CFG_DATA_W-1:0] data);
      capacity_reg = data[CAP_W-1:0];
    endfunction

    function void check_capacity_read(logic [CFG_DATA_W-1:0] data);
      logic [CFG_DATA_W-1:0] want;
      want = {{(CFG_DATA_W - CAP_W){1'b0}}, capacity_reg};
      if (data !== want) begin
        log_failure($sformatf("capacity readback: expected %h got %h", want, data));
      end
    endfunction

    // entries more recent than s age by one, s becomes rank 0
    function void make_most_recent(int s);
      logic [RANK_W-1:0] old_rank;
      old_rank = slot_rank[s];
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
      end
      slot_rank[s] = '0;
    endfunction

    function void note_request(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
      lookup_result_t r;
      int hit_slot;
      int victim;
      int free_slot;
      hit_slot  = -1;
      victim    = -1;
      free_slot = -1;
      r = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_slot < 0 && slot_valid[i] && slot_key[i] == key) hit_slot = i;
      end
      if (cmd == CMD_GET) begin
        if (hit_slot >= 0) begin
          r.found      = 1'b1;
          r.read_value = slot_value[hit_slot];
          make_most_recent(hit_slot);
        end else begin
          r.read_value = MISS_VALUE;
        end
      end else if (hit_slot >= 0) begin
        r.found = 1'b1;
        slot_value[hit_slot] = value;
        make_most_recent(hit_slot);
      end else begin
        // full (or over a lowered capacity): drop exactly one oldest entry
        if (occupancy >= capacity_limit() && occupancy > 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
          end
          if (victim >= 0) begin
            slot_valid[victim] = 1'b0;
            occupancy--;
            r.evicted = 1'b1;
          end
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (free_slot < 0 && !slot_valid[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) slot_rank[i]++;
          end
          slot_valid[free_slot] = 1'b1;
          slot_key[free_slot]   = key;
          slot_value[free_slot] = value;
          slot_rank[free_slot]  = '0;
          occupancy++;
        end
      end
      owed_results.push_back(r);
    endfunction

    function void check_result(logic found, logic [VAL_W-1:0] read_value, logic evicted);
      lookup_result_t want;
      if (owed_results.size() == 0) begin
        log_failure($sformatf("result beat with nothing owed: found=%0b read_value=%h evicted=%0b",
                              found, read_value, evicted));
      end else begin
        want = owed_results.pop_front();
        if (want.found !== found || want.read_value !== read_value || want.evicted !== evicted)
        begin
          log_failure($sformatf({"result mismatch: expected found=%0b read_value=%h evicted=%0b,",
                                 " got found=%0b read_value=%h evicted=%0b"},
                                want.found, want.read_value, want.evicted,
                                found, read_value, evicted));
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and its ports
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always #6 clk = ~clk;

  logic                  in_valid;
  logic                  in_ready;
  logic                  in_cmd;
  logic [KEY_W-1:0]      in_key;
  logic [VAL_W-1:0]      in_value;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_found;
  logic [VAL_W-1:0]      out_read_value;
  logic                  out_evicted;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lru_key_value_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  cache_shadow shadow = new();

  // knobs shared between the stimulus thread and the result sink
  int ready_stall_pct = 0;     // chance per cycle of starting a stall burst
  int long_hold_cycles = 0;    // one-shot request for a long out_ready hold-off

  // --------------------------------------------------------------------------
  // Watchdog: a hang anywhere ends the run as a failure.
  // --------------------------------------------------------------------------
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result sink. All sampling is right after the edge, so values seen are
  // the ones the DUT saw at that edge. Stalls come in random bursts;
  // a long hold-off is counted here so the sender keeps pushing meanwhile.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) shadow.check_result(out_found, out_read_value, out_evicted);
      if (long_hold_cycles > 0) begin
        stall_left = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < ready_stall_pct) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  logic [KEY_W-1:0] key_pool[$];

  // Hold the beat until taken; valid is left high so back-to-back beats
  // never drop it within one step.
  task automatic send_request(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    shadow.note_request(cmd, key, value);
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Drop valid, let every owed result come back, then let the sequencer
  // finish whatever sweep it may still be in.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (shadow.owed_results.size() != 0) @(posedge clk);
    repeat (SWEEP_LATENCY) @(posedge clk);
  endtask

  // Keys are mostly drawn from a pool a little larger than the capacity so
  // hits, updates and evictions all keep happening. Some pool keys sit one
  // bit away from another to catch partial compares.
  task automatic fill_key_pool(int unsigned size);
    logic [KEY_W-1:0] k;
    key_pool.delete();
    for (int i = 0; i < size; i++) begin
      case ($urandom_range(0, 7))
        0: k = 32'h8000_0000;
        1: k = 32'h7FFF_FFFF;
        2: k = 32'hFFFF_FFFF;
        3: k = '0;
        4: begin
          if (key_pool.size() > 0)
            k = key_pool[$urandom_range(0, key_pool.size() - 1)] ^ (32'h1 << $urandom_range(0, 31));
          else
            k = $urandom();
        end
        default: k = $urandom();
      endcase
      key_pool.push_back(k);
    end
  endtask

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random_request();
    logic             cmd;
    logic [KEY_W-1:0] k;
    cmd = ($urandom_range(0, 99) < 45) ? CMD_GET : CMD_PUT;
    if ($urandom_range(0, 9) == 0) k = $urandom();   // almost surely a fresh key
    else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    send_request(cmd, k, random_value());
  endtask

  // --------------------------------------------------------------------------
  // APB: setup cycle, access cycle, done when pready is seen with penable.
  // --------------------------------------------------------------------------
  task automatic cfg_access(logic write, logic [CFG_ADDR_W-1:0] addr,
                            logic [CFG_DATA_W-1:0] wdata, output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are random; only the low CAP_W bits may stick. A stray
  // write to the unmapped index follows, then the readback must be unchanged.
  task automatic program_capacity(logic [CAP_W-1:0] cap);
    logic [CFG_DATA_W-1:0] word;
    logic [CFG_DATA_W-1:0] rd;
    word = $urandom();
    word[CAP_W-1:0] = cap;
    cfg_access(1'b1, CAP_ADDR, word, rd);
    shadow.set_capacity(word);
    cfg_access(1'b1, UNMAPPED_ADDR, $urandom(), rd);
    cfg_access(1'b0, CAP_ADDR, $urandom(), rd);
    shadow.check_capacity_read(rd);
  endtask

  // One phase of random traffic at a given capacity. A stress phase opens
  // with a long result hold-off (input backs up) and pauses halfway until
  // everything owed has drained.
  task automatic run_phase(logic [CAP_W-1:0] cap, int items, int gap_pct, int stall_pct,
                           bit stress);
    int unsigned eff;
    wait_until_idle();
    program_capacity(cap);
    ready_stall_pct = stall_pct;
    eff = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
    fill_key_pool(eff + $urandom_range(1, 6));
    if (stress) long_hold_cycles = LONG_HOLD;
    for (int n = 0; n < items; n++) begin
      if (stress && n == items / 2) wait_until_idle();
      send_random_request();
      sender_gap(gap_pct);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] rd;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_cmd      = CMD_GET;
    in_key      = '0;
    in_value    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the capacity register
    cfg_access(1'b0, CAP_ADDR, '0, rd);
    shadow.check_capacity_read(rd);

    // Directed: empty store, key extremes, update in place, a hit whose
    // stored value equals the miss code.
    send_request(CMD_GET, 32'h0000_0000, $urandom());
    send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(CMD_GET, 32'h8000_0000, $urandom());
    send_request(CMD_GET, 32'h8000_0001, $urandom());
    send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_request(CMD_GET, 32'h7FFF_FFFF, $urandom());
    send_request(CMD_GET, 32'h0000_0000, $urandom());
    send_request(CMD_GET, 32'hFFFF_FFFF, $urandom());

    // Capacity dropped below occupancy: each new key evicts one, nothing is
    // flushed by the write itself.
    wait_until_idle();
    program_capacity(5'd2);
    send_request(CMD_PUT, 32'h0000_0100, 32'hCAFE_0001);
    send_request(CMD_PUT, 32'h0000_0200, 32'hCAFE_0002);
    send_request(CMD_GET, 32'h8000_0000, $urandom());
    send_request(CMD_GET, 32'h0000_0100, $urandom());

    // zero capacity behaves as one
    wait_until_idle();
    program_capacity(5'd0);
    send_request(CMD_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(CMD_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(CMD_GET, 32'h5555_5555, $urandom());
    send_request(CMD_GET, 32'hAAAA_AAAA, $urandom());

    // out-of-range capacity clamps to the slot count
    wait_until_idle();
    program_capacity(5'd31);
    send_request(CMD_PUT, 32'h0BAD_F00D, 32'h0000_0001);
    send_request(CMD_PUT, 32'hF00D_0BAD, 32'hFFFF_FFFE);
    send_request(CMD_GET, 32'h0BAD_F00D, $urandom());
    send_request(CMD_GET, 32'hAAAA_AAAA, $urandom());

    // Random phases. Order matters: a full store at the clamped maximum is
    // followed by a capacity well below occupancy.
    run_phase(5'd16, 150, 20, 20, 1'b1);
    run_phase(5'd1,  100, 30, 30, 1'b0);
    run_phase(5'd0,   60, 10, 50, 1'b0);
    run_phase(5'd31, 120,  0,  0, 1'b0);
    run_phase(5'd5,  120, 15, 40, 1'b0);
    run_phase(5'd17, 120, 40, 15, 1'b0);
    run_phase(5'd8,  120, 25, 25, 1'b0);
    run_phase(5'd2,   80, 20, 10, 1'b0);
    // closing stretch at full rate on both sides
    run_phase(5'd12, 130,  0,  0, 1'b0);

    wait_until_idle();
    if (shadow.failures == 0 && shadow.owed_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: lru_key_value_cache.f
rtl/lkv_pkg.sv
rtl/lru_key_value_cache.sv
bench/lru_key_value_cache_test.sv
